// File: rtl/core/slfmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line framer message pool package
// Shared sizes, byte codes, request codes and the item and control types.
// ----------------------------------------------------------------------------
package slfmp_pkg;

   localparam int MSG_BYTES   = 64;
   localparam int POOL_SLOTS  = 8;

   localparam int SLOT_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int LEN_W       = $clog2(MSG_BYTES);
   localparam int STORE_DEPTH = POOL_SLOTS * MSG_BYTES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LINE_LIMIT  = MSG_BYTES - 2;

   // Field widths of the request and response items.
   localparam int REQ_TYPE_W  = 2;
   localparam int BYTE_W      = 8;
   localparam int OFFSET_W    = 6;
   localparam int DONE_SLOT_W = 3;
   localparam int DONE_LEN_W  = 6;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_RECV    = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ    = 2'd2;

   // Byte codes.
   localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [BYTE_W-1:0]     rx_byte;
      logic                  rx_overrun;
      logic [OFFSET_W-1:0]   read_offset;
   } req_item_type;

   typedef struct packed {
      logic                   byte_stored;
      logic                   line_done;
      logic [DONE_SLOT_W-1:0] done_slot;
      logic [DONE_LEN_W-1:0]  done_length;
      logic                   line_discarded;
      logic                   sync_error;
      logic                   lines_pending;
      logic [BYTE_W-1:0]      read_byte;
      logic                   release_ignored;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch the incoming request
      logic commit;     // execute a receive, release or idle request and load the response
      logic rd_issue;   // start the line store read for a read request
      logic rd_load;    // load the response of a read request
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_read;
      logic out_free;
   } ctrl_status_type;

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] result;
      if (slot == SLOT_W'(POOL_SLOTS - 1)) begin
         result = '0;
      end else begin
         result = slot + 1'b1;
      end
      return result;
   endfunction

endpackage

// File: rtl/core/slfmp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one framer request.
// ----------------------------------------------------------------------------
interface slfmp_req_if import slfmp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [BYTE_W-1:0]     rx_byte;
   logic                  rx_overrun;
   logic [OFFSET_W-1:0]   read_offset;

   modport source (output valid, output req_type, output rx_byte, output rx_overrun,
                   output read_offset, input ready);
   modport sink   (input valid, input req_type, input rx_byte, input rx_overrun,
                   input read_offset, output ready);
endinterface

// File: rtl/core/slfmp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one framer response.
// ----------------------------------------------------------------------------
interface slfmp_rsp_if import slfmp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   byte_stored;
   logic                   line_done;
   logic [DONE_SLOT_W-1:0] done_slot;
   logic [DONE_LEN_W-1:0]  done_length;
   logic                   line_discarded;
   logic                   sync_error;
   logic                   lines_pending;
   logic [BYTE_W-1:0]      read_byte;
   logic                   release_ignored;

   modport source (output valid, output byte_stored, output line_done, output done_slot,
                   output done_length, output line_discarded, output sync_error,
                   output lines_pending, output read_byte, output release_ignored,
                   input ready);
   modport sink   (input valid, input byte_stored, input line_done, input done_slot,
                   input done_length, input line_discarded, input sync_error,
                   input lines_pending, input read_byte, input release_ignored,
                   output ready);
endinterface

// File: rtl/core/slfmp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module slfmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/slfmp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer controller
// Sequences one request at a time through execute and, for reads, the
// line store read.
// ----------------------------------------------------------------------------
module slfmp_ctrl import slfmp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDWAIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_comb begin
      cmd          = '0;
      cmd.capture  = req_valid && ready_ff;
      cmd.commit   = (state_ff == ST_EXEC) && !status.is_read && status.out_free;
      cmd.rd_issue = (state_ff == ST_EXEC) && status.is_read;
      cmd.rd_load  = (state_ff == ST_RDWAIT) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= ST_EXEC;
                  ready_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               if (status.is_read) begin
                  state_ff <= ST_RDWAIT;
               end else if (status.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            ST_RDWAIT: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = ready_ff;

endmodule

// File: rtl/core/slfmp_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer datapath
// Slot pointers, line lengths, the line store and the response register.
// ----------------------------------------------------------------------------
module slfmp_dpath import slfmp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   input  req_item_type    req_item,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_item_type    rsp_item
);

   req_item_type      item_ff;
   logic [SLOT_W-1:0] ws_ff, ws_in;
   logic [SLOT_W-1:0] rs_ff, rs_in;
   logic              ovr_ff, ovr_in;
   logic [LEN_W-1:0]  len_ff [POOL_SLOTS];
   logic [LEN_W-1:0]  len_in [POOL_SLOTS];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic [SLOT_W-1:0] sel_slot;
   logic [LEN_W-1:0]  cur_len;
   logic [LEN_W-1:0]  len_app;
   logic [ADDR_W-1:0] ram_addr;
   logic [BYTE_W-1:0] ram_q;
   logic              ram_we;
   logic              is_term;
   logic              appended;
   logic              ovr_now;
   logic              discard;
   logic              rd_hit;

   assign status.is_read  = (item_ff.req_type == REQ_READ);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Reads look at the oldest slot, everything else at the slot being built.
   assign sel_slot = status.is_read ? rs_ff : ws_ff;
   assign cur_len  = len_ff[sel_slot];

   assign is_term  = (item_ff.rx_byte == BYTE_LF) || (item_ff.rx_byte == BYTE_CR);
   assign appended = !((cur_len == '0) && (item_ff.rx_byte < BYTE_SPACE));
   assign len_app  = cur_len + LEN_W'(appended);
   assign ovr_now  = ovr_ff || item_ff.rx_overrun;
   assign discard  = (len_app >= LEN_W'(LINE_LIMIT)) || ovr_now;
   assign rd_hit   = (32'(item_ff.read_offset) < 32'(cur_len)) &&
                     (32'(item_ff.read_offset) < 32'(MSG_BYTES));

   assign ram_we   = cmd.commit && (item_ff.req_type == REQ_RECV) && !is_term && appended;
   assign ram_addr = ADDR_W'(32'(sel_slot) * MSG_BYTES) +
                     (status.is_read ? ADDR_W'(item_ff.read_offset) : ADDR_W'(cur_len));

   slfmp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (item_ff.rx_byte),
      .rdata (ram_q)
   );

   always_comb begin
      ws_in        = ws_ff;
      rs_in        = rs_ff;
      ovr_in       = ovr_ff;
      len_in       = len_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.commit) begin
         rsp_in = '0;
         case (item_ff.req_type)
            REQ_RECV: begin
               if (!is_term) begin
                  ovr_in = ovr_now;
                  if (discard) begin
                     len_in[ws_ff]         = '0;
                     rsp_in.line_discarded = 1'b1;
                     if (ovr_now) begin
                        rsp_in.sync_error = 1'b1;
                        ovr_in            = 1'b0;
                     end
                  end else begin
                     len_in[ws_ff]      = len_app;
                     rsp_in.byte_stored = appended;
                  end
               end else begin
                  // A terminator leaves a latched overrun for the next data byte.
                  ovr_in = ovr_now;
                  if (cur_len != '0) begin
                     rsp_in.line_done   = 1'b1;
                     rsp_in.done_slot   = DONE_SLOT_W'(ws_ff);
                     rsp_in.done_length = DONE_LEN_W'(cur_len);
                     ws_in              = slot_next(ws_ff);
                  end
               end
            end
            REQ_RELEASE: begin
               if (rs_ff == ws_ff) begin
                  rsp_in.release_ignored = 1'b1;
               end else begin
                  len_in[rs_ff] = '0;
                  rs_in         = slot_next(rs_ff);
               end
            end
            default: begin
            end
         endcase
         rsp_in.lines_pending = (rs_in != ws_in);
         rsp_valid_in         = 1'b1;
      end

      if (cmd.rd_load) begin
         rsp_in               = '0;
         rsp_in.read_byte     = rd_hit ? ram_q : '0;
         rsp_in.lines_pending = (rs_ff != ws_ff);
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff        <= '0;
         rs_ff        <= '0;
         ovr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < POOL_SLOTS; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         ws_ff        <= ws_in;
         rs_ff        <= rs_in;
         ovr_ff       <= ovr_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: rtl/core/serial_line_framer_message_pool_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line framer message pool
// Builds CR/LF terminated lines from received bytes in a ring of message
// slots, and releases and reads the oldest line.
//
//   Channel    Dir  Handshake     Contents
//   req_chan   in   valid/ready   req_type, rx_byte, rx_overrun, read_offset
//   rsp_chan   out  valid/ready   one response per request
//
// A receive, release or idle request passes the execute step before the next
// acceptance; a read passes the execute step and then the read-wait step for
// the registered line store read.
// One request is in the block at a time; the next is taken while the
// previous response still waits in the output register.
// A stalled response holds the block in its execute or read-wait step until it drains.
// Synchronous reset clears the slot pointers and all line lengths at once.
// ----------------------------------------------------------------------------
module serial_line_framer_message_pool_core import slfmp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   slfmp_req_if.sink    req_chan,
   slfmp_rsp_if.source  rsp_chan
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   req_item_type    req_item;
   rsp_item_type    rsp_item;
   logic            req_ready;
   logic            rsp_valid;

   assign req_item.req_type    = req_chan.req_type;
   assign req_item.rx_byte     = req_chan.rx_byte;
   assign req_item.rx_overrun  = req_chan.rx_overrun;
   assign req_item.read_offset = req_chan.read_offset;
   assign req_chan.ready       = req_ready;

   slfmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   slfmp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.byte_stored     = rsp_item.byte_stored;
   assign rsp_chan.line_done       = rsp_item.line_done;
   assign rsp_chan.done_slot       = rsp_item.done_slot;
   assign rsp_chan.done_length     = rsp_item.done_length;
   assign rsp_chan.line_discarded  = rsp_item.line_discarded;
   assign rsp_chan.sync_error      = rsp_item.sync_error;
   assign rsp_chan.lines_pending   = rsp_item.lines_pending;
   assign rsp_chan.read_byte       = rsp_item.read_byte;
   assign rsp_chan.release_ignored = rsp_item.release_ignored;

   // Only one request is in flight: acceptance drops ready for the next cycle.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // A new response appears only after the datapath loaded one.
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit || cmd.rd_load))
      else $error("response valid without a load");

   // A completed line never also reports a stored byte, a discarded line or an ignored release.
   a_done_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.line_done) |->
         (!rsp_item.byte_stored && !rsp_item.line_discarded && !rsp_item.release_ignored))
      else $error("line completion mixed with other results");

   // A sync error always comes with a discarded line.
   a_sync_discard: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.sync_error) |-> rsp_item.line_discarded)
      else $error("sync error without a discard");

   // Commit is never requested together with a read issue or a read load.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && (cmd.rd_issue || cmd.rd_load)))
      else $error("conflicting datapath commands");

endmodule

// File: bench/serial_line_framer_message_pool_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line framer message pool testbench
// Drives receive, release and read requests into the framer and checks every
// response against a line pool predictor kept in the bench. A directed
// opening covers the corner cases of line framing and overrun handling.
// Random traffic follows, mostly well-formed lines with some noise. It runs
// under several source idle and sink stall mixes, plus one long sink
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module serial_line_framer_message_pool_core_tb;
   import slfmp_pkg::*;

   // Request code that the block does not define.
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   // Predicts each response from the requests seen so far and holds the
   // predictions until the block returns them.
   class framer_scoreboard;
      logic [BYTE_W-1:0] line_mem [STORE_DEPTH];
      int unsigned       line_len [POOL_SLOTS];
      logic [SLOT_W-1:0] wr_slot;
      logic [SLOT_W-1:0] rd_slot;
      bit                overrun_latched;
      rsp_item_type      expected_q [$];
      int unsigned       errors;
      int unsigned       checked;
      int unsigned       lines_closed;
      int unsigned       discards;
      int unsigned       sync_errors;
      int unsigned       reads_hit;

      function new();
         foreach (line_len[i]) line_len[i] = 0;
         wr_slot         = '0;
         rd_slot         = '0;
         overrun_latched = 1'b0;
         errors          = 0;
         checked         = 0;
         lines_closed    = 0;
         discards        = 0;
         sync_errors     = 0;
         reads_hit       = 0;
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type e;
         int unsigned  len;
         bit           appended;
         e = '0;
         case (r.req_type)
            REQ_RECV: begin
               if (r.rx_overrun) overrun_latched = 1'b1;
               if (r.rx_byte != BYTE_LF && r.rx_byte != BYTE_CR) begin
                  len      = line_len[wr_slot];
                  appended = 1'b0;
                  // A control character cannot open a line.
                  if (!(len == 0 && r.rx_byte < BYTE_SPACE)) begin
                     if (len < MSG_BYTES) begin
                        line_mem[int'(wr_slot) * MSG_BYTES + len] = r.rx_byte;
                        len++;
                     end
                     appended = 1'b1;
                  end
                  if (len >= LINE_LIMIT || overrun_latched) begin
                     len              = 0;
                     e.line_discarded = 1'b1;
                     discards++;
                     if (overrun_latched) begin
                        e.sync_error    = 1'b1;
                        overrun_latched = 1'b0;
                        sync_errors++;
                     end
                  end else if (appended) begin
                     e.byte_stored = 1'b1;
                  end
                  line_len[wr_slot] = len;
               end else if (line_len[wr_slot] > 0) begin
                  // The overrun flag survives a terminator on purpose.
                  e.line_done   = 1'b1;
                  e.done_slot   = DONE_SLOT_W'(wr_slot);
                  e.done_length = DONE_LEN_W'(line_len[wr_slot]);
                  wr_slot       = SLOT_W'((int'(wr_slot) + 1) % POOL_SLOTS);
                  lines_closed++;
               end
            end
            REQ_RELEASE: begin
               if (rd_slot == wr_slot) begin
                  e.release_ignored = 1'b1;
               end else begin
                  line_len[rd_slot] = 0;
                  rd_slot           = SLOT_W'((int'(rd_slot) + 1) % POOL_SLOTS);
               end
            end
            REQ_READ: begin
               if (r.read_offset < line_len[rd_slot]) begin
                  e.read_byte = line_mem[int'(rd_slot) * MSG_BYTES + r.read_offset];
                  reads_hit++;
               end
            end
            default: begin
            end
         endcase
         e.lines_pending = (rd_slot != wr_slot);
         expected_q.push_back(e);
      endfunction

      function void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
         if (act_val !== exp_val) begin
            errors++;
            if (errors <= 200) begin
               $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                        $time, name, exp_val, act_val);
            end
         end
      endfunction

      function void check_response(rsp_item_type a);
         rsp_item_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t ns: response with no request outstanding, actual %0h", $time, a);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         check_field("byte_stored", e.byte_stored, a.byte_stored);
         check_field("line_done", e.line_done, a.line_done);
         check_field("done_slot", e.done_slot, a.done_slot);
         check_field("done_length", e.done_length, a.done_length);
         check_field("line_discarded", e.line_discarded, a.line_discarded);
         check_field("sync_error", e.sync_error, a.sync_error);
         check_field("lines_pending", e.lines_pending, a.lines_pending);
         check_field("read_byte", e.read_byte, a.read_byte);
         check_field("release_ignored", e.release_ignored, a.release_ignored);
      endfunction
   endclass

   logic clock;
   logic reset;

   slfmp_req_if req_chan ();
   slfmp_rsp_if rsp_chan ();

   serial_line_framer_message_pool_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   framer_scoreboard sb;
   int unsigned      items_sent;
   int               src_idle_pct;
   int               rsp_stall_pct;
   bit               rsp_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("Timeout: the run did not finish in time.");
      $display("CHECKS FAILED");
      $finish;
   end

   // Sink side: ready changes only at the falling edge.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_item_type act;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         act.byte_stored     = rsp_chan.byte_stored;
         act.line_done       = rsp_chan.line_done;
         act.done_slot       = rsp_chan.done_slot;
         act.done_length     = rsp_chan.done_length;
         act.line_discarded  = rsp_chan.line_discarded;
         act.sync_error      = rsp_chan.sync_error;
         act.lines_pending   = rsp_chan.lines_pending;
         act.read_byte       = rsp_chan.read_byte;
         act.release_ignored = rsp_chan.release_ignored;
         sb.check_response(act);
      end
   end

   task automatic send_req(input logic [REQ_TYPE_W-1:0] t, input logic [BYTE_W-1:0] b,
                           input logic o, input logic [OFFSET_W-1:0] off);
      req_item_type r;
      r.req_type    = t;
      r.rx_byte     = b;
      r.rx_overrun  = o;
      r.read_offset = off;
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= r.req_type;
      req_chan.rx_byte     <= r.rx_byte;
      req_chan.rx_overrun  <= r.rx_overrun;
      req_chan.read_offset <= r.read_offset;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(r);
      items_sent++;
   endtask

   // One line of random content closed by CR or LF, sometimes as CR LF.
   task automatic send_line();
      int               n;
      int               pick;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] term;
      pick = $urandom_range(99);
      if (pick < 85) n = $urandom_range(1, 12);
      else if (pick < 95) n = $urandom_range(13, 61);
      else n = $urandom_range(58, 64);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0) begin
            b = BYTE_W'($urandom_range(255));
            if (b == BYTE_LF || b == BYTE_CR) b = 8'h00;
         end else begin
            b = BYTE_W'($urandom_range(8'h20, 8'hFF));
         end
         send_req(REQ_RECV, b, $urandom_range(99) < 2, OFFSET_W'($urandom_range(63)));
      end
      term = $urandom_range(1) ? BYTE_CR : BYTE_LF;
      send_req(REQ_RECV, term, $urandom_range(99) < 3, OFFSET_W'($urandom_range(63)));
      if (term == BYTE_CR && $urandom_range(1)) begin
         send_req(REQ_RECV, BYTE_LF, 1'b0, OFFSET_W'($urandom_range(63)));
      end
   endtask

   task automatic run_random(input int n, input int idle_pct, input int stall_pct);
      int unsigned target;
      int          pick;
      logic [1:0]  t;
      src_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      target        = items_sent + n;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_line();
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 3)) begin
               send_req(REQ_READ, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                        ($urandom_range(9) < 7) ? OFFSET_W'($urandom_range(15)) :
                                                  OFFSET_W'($urandom_range(63)));
            end
         end else if (pick < 88) begin
            send_req(REQ_RELEASE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                     OFFSET_W'($urandom_range(63)));
         end else begin
            // Noise: any byte, frequent overruns, now and then an unknown request code.
            t = ($urandom_range(19) == 0) ? REQ_UNUSED : REQ_RECV;
            send_req(t, BYTE_W'($urandom_range(255)), $urandom_range(9) == 0,
                     OFFSET_W'($urandom_range(63)));
         end
      end
   endtask

   initial begin
      int unsigned drain;
      sb                   = new();
      items_sent           = 0;
      src_idle_pct         = 0;
      rsp_stall_pct        = 0;
      rsp_hold             = 1'b0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_RECV;
      req_chan.rx_byte     = '0;
      req_chan.rx_overrun  = 1'b0;
      req_chan.read_offset = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening on an empty pool.
      send_req(REQ_RELEASE, 8'h00, 1'b0, 6'd0);
      send_req(REQ_READ, 8'h00, 1'b0, 6'd0);
      send_req(REQ_UNUSED, 8'hFF, 1'b1, 6'd63);
      send_req(REQ_RECV, 8'h01, 1'b0, 6'd0);
      send_req(REQ_RECV, BYTE_LF, 1'b0, 6'd0);
      send_req(REQ_RECV, BYTE_SPACE, 1'b0, 6'd0);
      send_req(REQ_RECV, 8'hFF, 1'b0, 6'd0);
      send_req(REQ_RECV, 8'h00, 1'b0, 6'd0);
      send_req(REQ_RECV, 8'h7F, 1'b0, 6'd0);
      send_req(REQ_RECV, BYTE_CR, 1'b0, 6'd0);
      send_req(REQ_READ, 8'h00, 1'b0, 6'd0);
      send_req(REQ_READ, 8'h00, 1'b0, 6'd3);
      send_req(REQ_READ, 8'h00, 1'b0, 6'd4);
      send_req(REQ_READ, 8'hFF, 1'b1, 6'd63);
      // Overrun flagged on a terminator stays latched for the next byte.
      send_req(REQ_RECV, 8'h41, 1'b0, 6'd0);
      send_req(REQ_RECV, BYTE_CR, 1'b1, 6'd0);
      send_req(REQ_RECV, 8'h05, 1'b0, 6'd0);
      send_req(REQ_RECV, 8'h1F, 1'b1, 6'd0);
      // Overrun on a byte that would have been stored.
      send_req(REQ_RECV, 8'h42, 1'b0, 6'd0);
      send_req(REQ_RECV, 8'h43, 1'b1, 6'd0);
      send_req(REQ_RELEASE, 8'h00, 1'b0, 6'd0);
      send_req(REQ_READ, 8'h00, 1'b0, 6'd0);
      send_req(REQ_RELEASE, 8'h00, 1'b0, 6'd0);
      send_req(REQ_RELEASE, 8'h00, 1'b0, 6'd0);

      run_random(480, 0, 0);
      run_random(480, 64, 0);
      run_random(480, 0, 64);
      run_random(480, 23, 23);

      // Long sink hold-off while the source keeps offering requests.
      src_idle_pct  = 0;
      rsp_stall_pct = 0;
      fork
         begin
            rsp_hold = 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold = 1'b0;
         end
         begin
            repeat (6) send_line();
         end
      join

      @(negedge clock);
      req_chan.valid <= 1'b0;

      drain = 0;
      while (sb.expected_q.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         $display("%0t ns: %0d expected responses never arrived", $time,
                  sb.expected_q.size());
         sb.errors += sb.expected_q.size();
      end

      $display("Covered %0d requests and %0d responses: %0d lines closed, %0d reads of data.",
               items_sent, sb.checked, sb.lines_closed, sb.reads_hit);
      $display("Lines discarded: %0d, of them on overrun: %0d; mismatches: %0d.",
               sb.discards, sb.sync_errors, sb.errors);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/slfmp_pkg.sv
rtl/core/slfmp_req_if.sv
rtl/core/slfmp_rsp_if.sv
rtl/core/slfmp_ram.sv
rtl/core/slfmp_ctrl.sv
rtl/core/slfmp_dpath.sv
rtl/core/serial_line_framer_message_pool_core.sv
bench/serial_line_framer_message_pool_core_tb.sv
